/* sv/mfe_pkg.sv */
// Shared types and constants for the metaball field evaluator.
// No dependencies; imported by every module of the block.
package mfe_pkg;

   localparam int COORD_W  = 16;
   localparam int DIST_W   = 34;
   localparam int DSQ_W    = 68;
   localparam int FQ_W     = 40;
   localparam int GMAG_W   = 34;
   localparam int FACC_W   = 53;
   localparam int GACC_W   = 47;
   localparam int ENTRY_W  = 3 * COORD_W;
   localparam int REQ_W    = 56;
   localparam int RSP_W    = 128;

   // Item kinds carried on the request tuser bit
   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

   // Configuration register indexes
   localparam logic CSR_RADIUS_SQ    = 1'b0;
   localparam logic CSR_SPHERE_COUNT = 1'b1;

   // Per-centre result from the term unit
   typedef struct packed {
      logic                        done;
      logic                        zero;
      logic [2:0]                  cap;
      logic [2:0]                  neg;
      logic [FQ_W-1:0]             field;
      logic [2:0][GMAG_W-1:0]      grad;
   } mfe_term_rsp_type;

endpackage

/* sv/metaball_field_evaluator_core.sv */
// Metaball field evaluator: centre table, walk sequencer, accumulators, result register.
// Depends on mfe_pkg, mfe_store and mfe_term.
//
// Use: request items on req_ (tuser = kind: 0 writes a centre, 1 queries a point).
// A write stores coord x/y/z at entry_index and gives no result.
// A query walks entries 0..sphere_count-1 (capped at MAX_SPHERES), one after the
// other, and returns one item on rsp_ with field sum, gradient and the clip flag.
// For each centre the walk runs a table read, a start step, four setup steps, a
// 40-step bit-serial divide and a done step in the term unit; a zero distance
// skips the divide. An empty table gives an all-zero result. req_tready is high
// only between items.
// Results sit in an output register: the next item is accepted while a result
// waits, and a finished query holds until rsp_tready frees the register.
// Reset (synchronous) sets radius_sq to 1.0, sphere_count to 0 and empties the
// result register; table contents are undefined until written. csr_ writes take
// effect at once; the user must do them only while the block is idle (not enforced).
module metaball_field_evaluator_core import mfe_pkg::*; #(
   parameter int MAX_SPHERES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // [7:0] entry_index, [23:8] coord_x, [39:24] coord_y, [55:40] coord_z
   input  logic [REQ_W-1:0]  req_tdata,
   // [0] req_type
   input  logic              req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // [31:0] field_sum, [63:32] grad_x, [95:64] grad_y, [127:96] grad_z
   output logic [RSP_W-1:0]  rsp_tdata,
   // [0] clipped
   output logic              rsp_tuser,
   input  logic              csr_we,
   input  logic              csr_addr,
   input  logic [15:0]       csr_wdata
);

   localparam int AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
   localparam int CW = $clog2(MAX_SPHERES + 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,
      S_START = 5'b00100,
      S_TERM  = 5'b01000,
      S_OUT   = 5'b10000
   } core_state_type;

   core_state_type state_ff, state_in;
   logic [15:0]   radius_sq_ff;
   logic [8:0]    sphere_count_ff;
   logic [CW-1:0] idx_ff, cnt_ff;
   logic [2:0][COORD_W-1:0] point_ff;
   logic [FACC_W-1:0]              field_acc_ff;
   logic signed [2:0][GACC_W-1:0]  grad_acc_ff;
   logic          clip_ff;
   logic          rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;
   logic          rsp_user_ff;

   logic          accept, wr_en, rd_en, out_load;
   logic [CW-1:0] cnt_in;
   logic [ENTRY_W-1:0] rd_data;
   mfe_term_rsp_type   term_rsp;
   logic [31:0]        field_out;
   logic [2:0][31:0]   grad_out;
   logic               clip_out;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign wr_en      = accept && (req_tuser == REQ_WRITE)
                       && (32'(req_tdata[7:0]) < 32'(MAX_SPHERES));
   assign rd_en      = (state_ff == S_READ);
   assign out_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);
   assign cnt_in     = (32'(sphere_count_ff) > 32'(MAX_SPHERES)) ?
                       CW'(MAX_SPHERES) : CW'(sphere_count_ff);

   mfe_store #(.DEPTH(MAX_SPHERES), .AW(AW)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_tdata[7:0])),
      .wr_data (req_tdata[55:8]),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   mfe_term u_term (
      .clock     (clock),
      .reset     (reset),
      .start     (state_ff == S_START),
      .centre    (rd_data),
      .point     (point_ff),
      .radius_sq (radius_sq_ff),
      .rsp       (term_rsp)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_sq_ff    <= 16'd256;
         sphere_count_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_RADIUS_SQ:    radius_sq_ff    <= csr_wdata;
            CSR_SPHERE_COUNT: sphere_count_ff <= csr_wdata[8:0];
            default: begin
            end
         endcase
      end
   end

   // Walk sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_tuser == REQ_QUERY)) begin
               state_in = (cnt_in == '0) ? S_OUT : S_READ;
            end
         end
         S_READ:  state_in = S_START;
         S_START: state_in = S_TERM;
         S_TERM: begin
            if (term_rsp.done) state_in = (idx_ff + CW'(1) == cnt_ff) ? S_OUT : S_READ;
         end
         S_OUT: if (out_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // Latch the query and accumulate the terms
   always_ff @(posedge clock) begin
      if (accept && (req_tuser == REQ_QUERY)) begin
         point_ff     <= req_tdata[55:8];
         cnt_ff       <= cnt_in;
         idx_ff       <= '0;
         field_acc_ff <= '0;
         grad_acc_ff  <= '0;
         clip_ff      <= 1'b0;
      end else if ((state_ff == S_TERM) && term_rsp.done) begin
         idx_ff <= idx_ff + CW'(1);
         if (term_rsp.zero) begin
            field_acc_ff <= field_acc_ff + FACC_W'(32'hFFFF_FFFF);
            clip_ff      <= 1'b1;
         end else begin
            field_acc_ff <= field_acc_ff + FACC_W'(term_rsp.field);
            clip_ff      <= clip_ff | (|term_rsp.cap);
            for (int c = 0; c < 3; c++) begin
               grad_acc_ff[c] <= term_rsp.neg[c] ?
                  grad_acc_ff[c] - GACC_W'(term_rsp.grad[c]) :
                  grad_acc_ff[c] + GACC_W'(term_rsp.grad[c]);
            end
         end
      end
   end

   // Saturate the sums
   always_comb begin
      clip_out  = clip_ff;
      field_out = field_acc_ff[31:0];
      if (field_acc_ff > FACC_W'(32'hFFFF_FFFF)) begin
         field_out = 32'hFFFF_FFFF;
         clip_out  = 1'b1;
      end
      for (int c = 0; c < 3; c++) begin
         grad_out[c] = grad_acc_ff[c][31:0];
         if ($signed(grad_acc_ff[c]) > $signed(GACC_W'(32'sh7FFF_FFFF))) begin
            grad_out[c] = 32'h7FFF_FFFF;
            clip_out    = 1'b1;
         end else if ($signed(grad_acc_ff[c]) < -$signed(GACC_W'(33'sh0_8000_0000))) begin
            grad_out[c] = 32'h8000_0000;
            clip_out    = 1'b1;
         end
      end
   end

   // Result register: load when free, drop on take
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= {grad_out[2], grad_out[1], grad_out[0], field_out};
         rsp_user_ff <= clip_out;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

/* sv/mfe_store.sv */
// Centre table: one write port, one read port, registered read data.
// Depends on mfe_pkg for the entry width.
module mfe_store import mfe_pkg::*; #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [ENTRY_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output logic [ENTRY_W-1:0] rd_data
);

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read one entry, data on the next cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/mfe_term.sv */
// Term unit: field and gradient terms for one centre, restoring division one bit a cycle.
// Depends on mfe_pkg for widths and the result struct.
module mfe_term import mfe_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [2:0][COORD_W-1:0]   centre,
   input  logic [2:0][COORD_W-1:0]   point,
   input  logic [15:0]               radius_sq,
   output mfe_term_rsp_type          rsp
);

   localparam int FDIV_W = DIST_W + FQ_W - 1;
   localparam int GN_W   = 65;
   localparam int GDIV_W = DSQ_W + FQ_W - 1;

   typedef enum logic [6:0] {
      T_IDLE = 7'b0000001,
      T_SQ   = 7'b0000010,
      T_SUM  = 7'b0000100,
      T_MUL  = 7'b0001000,
      T_DSQ  = 7'b0010000,
      T_DIV  = 7'b0100000,
      T_DONE = 7'b1000000
   } term_state_type;

   term_state_type state_ff, state_in;
   logic [5:0]  step_ff, step_in;

   logic [2:0][15:0]        mag_ff;
   logic [2:0]              neg_ff;
   logic [2:0][31:0]        sq_ff;
   logic [2:0][31:0]        num_ff;
   logic [DIST_W-1:0]       dist_ff;
   logic [63:0]             pp_ll_ff;
   logic [DIST_W-1:0]       pp_x_ff;
   logic                    zero_ff;
   logic [FQ_W-1:0]         fn_ff;
   logic [FDIV_W-1:0]       fdiv_ff;
   logic [FQ_W-1:0]         fq_ff;
   logic [2:0][GN_W-1:0]    gn_ff;
   logic [GDIV_W-1:0]       gdiv_ff;
   logic [2:0][FQ_W-1:0]    gq_ff;

   logic [2:0][16:0]        diff;
   logic [DSQ_W-1:0]        dsq;
   logic                    fge;
   logic [2:0]              gge;

   // Differences centre minus point
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         diff[c] = {centre[c][15], centre[c]} - {point[c][15], point[c]};
      end
   end

   // Squared distance squared from the partial products
   assign dsq = {4'b0, pp_ll_ff}
              + {1'b0, pp_x_ff, 33'b0}
              + {{2'b0, dist_ff[33:32]} * {2'b0, dist_ff[33:32]}, 64'b0};

   // Division compare for this step
   always_comb begin
      fge = {{(FDIV_W-FQ_W){1'b0}}, fn_ff} >= fdiv_ff;
      for (int c = 0; c < 3; c++) begin
         gge[c] = {{(GDIV_W-GN_W){1'b0}}, gn_ff[c]} >= gdiv_ff;
      end
   end

   // Sequence the steps
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         T_IDLE: if (start) state_in = T_SQ;
         T_SQ:   state_in = T_SUM;
         T_SUM:  state_in = T_MUL;
         T_MUL:  state_in = T_DSQ;
         T_DSQ: begin
            step_in  = 6'(FQ_W - 1);
            state_in = (dist_ff == '0) ? T_DONE : T_DIV;
         end
         T_DIV: begin
            step_in = step_ff - 6'd1;
            if (step_ff == '0) state_in = T_DONE;
         end
         T_DONE: state_in = T_IDLE;
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         T_IDLE: begin
            for (int c = 0; c < 3; c++) begin
               neg_ff[c] <= diff[c][16];
               mag_ff[c] <= diff[c][16] ? 16'(-diff[c]) : diff[c][15:0];
            end
         end
         T_SQ: begin
            for (int c = 0; c < 3; c++) begin
               sq_ff[c]  <= mag_ff[c] * mag_ff[c];
               num_ff[c] <= mag_ff[c] * radius_sq;
            end
         end
         T_SUM: begin
            dist_ff <= {2'b0, sq_ff[0]} + {2'b0, sq_ff[1]} + {2'b0, sq_ff[2]};
         end
         T_MUL: begin
            pp_ll_ff <= dist_ff[31:0] * dist_ff[31:0];
            pp_x_ff  <= {2'b0, dist_ff[31:0]} * {32'b0, dist_ff[33:32]};
         end
         T_DSQ: begin
            zero_ff <= (dist_ff == '0);
            fn_ff   <= {radius_sq, 24'b0};
            fdiv_ff <= {dist_ff, 39'b0};
            fq_ff   <= '0;
            gdiv_ff <= {dsq, 39'b0};
            for (int c = 0; c < 3; c++) begin
               gn_ff[c] <= {num_ff[c], 1'b0, 32'b0};
               gq_ff[c] <= '0;
            end
         end
         T_DIV: begin
            if (fge) fn_ff <= fn_ff - fdiv_ff[FQ_W-1:0];
            fq_ff   <= {fq_ff[FQ_W-2:0], fge};
            fdiv_ff <= fdiv_ff >> 1;
            gdiv_ff <= gdiv_ff >> 1;
            for (int c = 0; c < 3; c++) begin
               if (gge[c]) gn_ff[c] <= gn_ff[c] - gdiv_ff[GN_W-1:0];
               gq_ff[c] <= {gq_ff[c][FQ_W-2:0], gge[c]};
            end
         end
         default: begin
         end
      endcase
   end

   // Result, capped gradient magnitudes
   always_comb begin
      rsp.done  = (state_ff == T_DONE);
      rsp.zero  = zero_ff;
      rsp.neg   = neg_ff;
      rsp.field = fq_ff;
      for (int c = 0; c < 3; c++) begin
         rsp.cap[c]  = |gq_ff[c][FQ_W-1:33];
         rsp.grad[c] = rsp.cap[c] ? {1'b1, 33'b0} : {1'b0, gq_ff[c][32:0]};
      end
   end

endmodule

/* sv/mfe_checker.sv */
// Port-level checks for the metaball field evaluator, bound to the top level.
// Depends on metaball_field_evaluator_core and mfe_pkg.
module mfe_checker import mfe_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             req_tuser,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result dropped or changed");

   // Empty the result register at reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Go busy after a query is taken
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == REQ_QUERY) |=> !req_tready)
      else $error("request taken during a query");

   // Raise a result only out of a running query
   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared while idle");

endmodule

bind metaball_field_evaluator_core mfe_checker u_mfe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* test/metaball_field_evaluator_core_tb.sv */
// Self-checking testbench for metaball_field_evaluator_core: centre writes, field queries,
// random stalls on both streams. Depends on mfe_pkg and the block's RTL only.
`timescale 1ns / 100ps

module metaball_field_evaluator_core_tb;
   import mfe_pkg::*;

   localparam int N_ENTRIES   = 256;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      logic [31:0] field_sum;
      logic [31:0] grad_x;
      logic [31:0] grad_y;
      logic [31:0] grad_z;
      logic        clipped;
   } field_rsp_type;

   // Field and gradient predictor with its own copy of table and registers
   class field_scoreboard;
      logic signed [15:0] centre [N_ENTRIES][3];
      logic [15:0]        radius_sq;
      logic [8:0]         sphere_count;
      field_rsp_type      expected_q[$];
      int                 errors;

      function new();
         radius_sq    = 16'd256;
         sphere_count = 9'd0;
         errors       = 0;
      endfunction

      function void set_reg(logic addr, logic [15:0] value);
         if (addr == CSR_RADIUS_SQ)
            radius_sq = value;
         else
            sphere_count = value[8:0];
      endfunction

      function logic [31:0] clamp32(longint v, inout bit clip);
         if (v > 64'sd2147483647) begin
            clip = 1;
            v = 64'sd2147483647;
         end
         if (v < -64'sd2147483648) begin
            clip = 1;
            v = -64'sd2147483648;
         end
         return v[31:0];
      endfunction

      // Note one accepted item: store a centre or predict a query result
      function void note_item(req_kind_type kind, logic [7:0] idx,
                              logic signed [15:0] px, logic signed [15:0] py,
                              logic signed [15:0] pz);
         longint            d [3];
         longint            gsum [3];
         longint unsigned   dist2;
         longint unsigned   fsum;
         logic [127:0]      num;
         logic [127:0]      dsq;
         logic [127:0]      q;
         logic signed [15:0] p [3];
         int                count;
         bit                clip;
         field_rsp_type     r;
         p[0] = px;
         p[1] = py;
         p[2] = pz;
         if (kind == REQ_WRITE) begin
            for (int c = 0; c < 3; c++)
               centre[idx][c] = p[c];
            return;
         end
         count = (sphere_count > N_ENTRIES) ? N_ENTRIES : sphere_count;
         fsum = 0;
         clip = 0;
         for (int c = 0; c < 3; c++)
            gsum[c] = 0;
         for (int i = 0; i < count; i++) begin
            dist2 = 0;
            for (int c = 0; c < 3; c++) begin
               d[c] = longint'(centre[i][c]) - longint'(p[c]);
               dist2 += d[c] * d[c];
            end
            // zero distance: field saturates, no gradient
            if (dist2 == 0) begin
               clip = 1;
               fsum += 64'hFFFF_FFFF;
               continue;
            end
            fsum += (longint'(radius_sq) << 24) / dist2;
            dsq = 128'(dist2) * 128'(dist2);
            for (int c = 0; c < 3; c++) begin
               num = 128'(2) * 128'(radius_sq) * 128'((d[c] < 0) ? -d[c] : d[c]);
               q = (num << 32) / dsq;
               // cap huge gradient terms
               if (q >= (128'(1) << 33)) begin
                  clip = 1;
                  q = 128'(1) << 33;
               end
               gsum[c] += (d[c] < 0) ? -longint'(q) : longint'(q);
            end
         end
         if (fsum > 64'hFFFF_FFFF) begin
            clip = 1;
            fsum = 64'hFFFF_FFFF;
         end
         r.field_sum = fsum[31:0];
         r.grad_x    = clamp32(gsum[0], clip);
         r.grad_y    = clamp32(gsum[1], clip);
         r.grad_z    = clamp32(gsum[2], clip);
         r.clipped   = clip;
         expected_q = {expected_q, r};
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
         errors++;
      endtask

      // Compare one result against the oldest prediction
      task check_result(logic [RSP_W-1:0] data, logic user);
         field_rsp_type e;
         if (expected_q.size() == 0) begin
            report("unexpected result", data[31:0], 32'd0);
            return;
         end
         e = expected_q.pop_front();
         if (data[31:0] !== e.field_sum) report("field_sum", data[31:0], e.field_sum);
         if (data[63:32] !== e.grad_x) report("grad_x", data[63:32], e.grad_x);
         if (data[95:64] !== e.grad_y) report("grad_y", data[95:64], e.grad_y);
         if (data[127:96] !== e.grad_z) report("grad_z", data[127:96], e.grad_z);
         if (user !== e.clipped) report("clipped", 32'(user), 32'(e.clipped));
      endtask

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;
   logic             csr_we;
   logic             csr_addr;
   logic [15:0]      csr_wdata;

   field_scoreboard sb = new();
   int  cycles = 0;
   int  rsp_stall = 0;
   bit  long_hold = 0;
   int  active_count = 0;

   metaball_field_evaluator_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watch both streams and the register port
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_item(req_kind_type'(req_tuser), req_tdata[7:0], req_tdata[23:8],
                         req_tdata[39:24], req_tdata[55:40]);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tuser);
         if (csr_we)
            sb.set_reg(csr_addr, csr_wdata);
      end
   end

   // Receiver: random short stalls, a few long ones, one very long hold
   always @(posedge clock) begin
      if (long_hold) begin
         long_hold <= 0;
         rsp_stall <= 3000;
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(7) == 0) begin
         rsp_stall <= ($urandom_range(9) == 0) ? $urandom_range(80, 20) : $urandom_range(3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Offer one item until taken, then idle for a random gap
   task send(req_kind_type kind, logic [7:0] idx, logic [15:0] x, logic [15:0] y,
             logic [15:0] z);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {z, y, x, idx};
      do @(posedge clock); while (!req_tready);
      case ($urandom_range(19))
         0: gap = $urandom_range(80, 20);
         1, 2, 3, 4, 5, 6, 7: gap = $urandom_range(3, 1);
         default: gap = 0;
      endcase
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Wait until every result is in, then let a trailing write settle
   task drain();
      if (req_tvalid) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task write_csr(logic addr, logic [15:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (addr == CSR_SPHERE_COUNT)
         active_count = (value > N_ENTRIES) ? N_ENTRIES : value;
   endtask

   function logic [15:0] rand_coord();
      case ($urandom_range(3))
         0: return 16'($urandom_range(255));
         1: return 16'($urandom_range(2047)) - 16'd1024;
         default: return 16'($urandom);
      endcase
   endfunction

   // Query near or at a stored centre, or anywhere
   task random_query();
      int e;
      if (active_count > 0 && $urandom_range(2) == 0) begin
         e = $urandom_range(active_count - 1);
         if ($urandom_range(1) == 0)
            send(REQ_QUERY, 8'($urandom), sb.centre[e][0], sb.centre[e][1], sb.centre[e][2]);
         else
            send(REQ_QUERY, 8'($urandom), sb.centre[e][0] + 16'($urandom_range(4)),
                 sb.centre[e][1] - 16'($urandom_range(4)), sb.centre[e][2]);
      end else begin
         send(REQ_QUERY, 8'($urandom), rand_coord(), rand_coord(), rand_coord());
      end
   endtask

   initial begin
      logic [15:0] radius_pick [5];
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      rsp_tready <= 1'b0;
      csr_we     <= 1'b0;
      csr_addr   <= 1'b0;
      csr_wdata  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, extreme centres, zero distance, huge gradients
      send(REQ_QUERY, 8'd0, 16'h1234, 16'h0000, 16'hFFFF);
      send(REQ_WRITE, 8'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send(REQ_WRITE, 8'd1, 16'h8000, 16'h8000, 16'h8000);
      send(REQ_WRITE, 8'd2, 16'h0000, 16'h0000, 16'h0000);
      send(REQ_WRITE, 8'd3, 16'h0001, 16'h0000, 16'h0000);
      send(REQ_WRITE, 8'd4, 16'h0100, 16'hFF00, 16'h0080);
      send(REQ_WRITE, 8'd5, 16'h0000, 16'h0002, 16'hFFFF);
      send(REQ_WRITE, 8'd6, 16'h4000, 16'hC000, 16'h0000);
      send(REQ_WRITE, 8'd7, 16'hFFFF, 16'h0001, 16'h0003);
      send(REQ_WRITE, 8'd255, 16'h5555, 16'hAAAA, 16'h00FF);
      write_csr(CSR_SPHERE_COUNT, 16'd8);
      send(REQ_QUERY, 8'd0, 16'h0000, 16'h0000, 16'h0000);
      send(REQ_QUERY, 8'd0, 16'h8000, 16'h8000, 16'h8000);
      send(REQ_QUERY, 8'd0, 16'h7FFF, 16'h8000, 16'h7FFF);
      send(REQ_QUERY, 8'd0, 16'h0000, 16'h0001, 16'h0000);
      write_csr(CSR_RADIUS_SQ, 16'hFFFF);
      send(REQ_QUERY, 8'd0, 16'h0002, 16'h0000, 16'h0000);
      send(REQ_QUERY, 8'd0, 16'h2000, 16'hE000, 16'h1000);
      write_csr(CSR_RADIUS_SQ, 16'h0000);
      send(REQ_QUERY, 8'd0, 16'h0000, 16'h0000, 16'h0000);
      send(REQ_QUERY, 8'd0, 16'h0010, 16'h0000, 16'h0000);

      // Random phases over several register settings
      radius_pick = '{16'd256, 16'hFFFF, 16'd0, 16'($urandom), 16'($urandom_range(4096))};
      for (int ph = 0; ph < 5; ph++) begin
         write_csr(CSR_RADIUS_SQ, radius_pick[ph]);
         write_csr(CSR_SPHERE_COUNT, 16'($urandom_range(8, 1)));
         // hold the result side so the block fills up and stalls its input
         if (ph == 2)
            long_hold = 1;
         for (int n = 0; n < 50; n++) begin
            if ($urandom_range(1) == 0)
               send(REQ_WRITE, 8'($urandom), rand_coord(), rand_coord(), rand_coord());
            else
               random_query();
         end
      end

      // Full table: fill every entry, then count above and at the maximum
      for (int e = 8; e < N_ENTRIES; e++)
         send(REQ_WRITE, 8'(e), rand_coord(), rand_coord(), rand_coord());
      write_csr(CSR_RADIUS_SQ, 16'($urandom));
      write_csr(CSR_SPHERE_COUNT, 16'd300);
      random_query();
      random_query();
      write_csr(CSR_SPHERE_COUNT, 16'd256);
      random_query();

      drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

/* metaball_field_evaluator_core.f */
sv/mfe_pkg.sv
sv/mfe_store.sv
sv/mfe_term.sv
sv/metaball_field_evaluator_core.sv
sv/mfe_checker.sv
test/metaball_field_evaluator_core_tb.sv
